>>> hw/rtl/cll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cll_pkg;

    // Slot array geometry
    localparam int SLOTS     = 64;
    localparam int ELEM_BITS = 32;
    localparam int PTR_W     = $clog2(SLOTS);

    // Field widths of the words
    localparam int MODE_W = 2;
    localparam int POS_W  = 6;
    localparam int ELEM_W = 32;
    localparam int LEN_W  = 6;
    localparam int STAT_W = 2;

    typedef logic [PTR_W-1:0] t_ptr;

    // Slot 0 heads the free chain, the last slot heads the data list.
    localparam t_ptr FREE_SLOT = t_ptr'(0);
    localparam t_ptr HEAD_SLOT = t_ptr'(SLOTS - 1);
    localparam t_ptr LAST_FREE = t_ptr'(SLOTS - 2);

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT   = 2'd0,
        MODE_DELETE   = 2'd1,
        MODE_TRAVERSE = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [POS_W-1:0]   position;
        logic signed [ELEM_W-1:0] element;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic signed [ELEM_W-1:0] element_out;
        logic [LEN_W-1:0]   list_length;
        logic               last;
    } t_out_word;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_INS_RD0,
        S_INS_FRESH,
        S_INS_UNFREE,
        S_W_HEAD,
        S_WALK,
        S_INS_LINK,
        S_DEL_V,
        S_DEL_F,
        S_DEL_H,
        S_T_HEAD,
        S_T_ADDR,
        S_T_DATA,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/cll_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, registered read; read data holds while i_re is low.
module cll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cursor_linked_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Cursor linked list engine: a list of up to 62 signed 32-bit elements kept in
// a 64-slot array whose links are slot numbers. Slot 0 heads the free chain,
// slot 63 heads the data list. Each input word is insert (before a 1-based
// position), delete (at a position) or traverse. Insert and delete give one
// result word with status and the new length; traverse gives one word per
// element in list order with last set on the final one (one word with
// element 0 if the list is empty). After reset the block writes the link of
// every slot to build the free chain before it raises o_in_ready. A word
// of an undefined mode gives one plain result word with status OK. One link
// is followed per cycle through the single read port of the link RAM; a
// traverse waits whenever the output register is full. Only one word is in
// work at a time; a finished result sits in the output register, so the
// next input word can be taken while the previous result waits.

module cursor_linked_list_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire cll_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output cll_pkg::t_out_word      o_out_word
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    cll_pkg::t_state    r_state, n_state;
    cll_pkg::t_mode     r_mode, n_mode;
    cll_pkg::t_status   r_status, n_status;
    logic [cll_pkg::POS_W-1:0]     r_cnt, n_cnt;       // links left to walk
    logic [cll_pkg::ELEM_W-1:0]    r_elem, n_elem;
    cll_pkg::t_ptr                 r_ptr, n_ptr;       // slot whose link is in flight
    cll_pkg::t_ptr                 r_slot, n_slot;     // fresh slot / victim
    logic [cll_pkg::LEN_W-1:0]     r_count, n_count;
    cll_pkg::t_ptr                 r_init_idx, n_init_idx;
    logic                          r_out_valid, n_out_valid;
    cll_pkg::t_out_word            r_out, n_out;

    // ---------------------------------------------------------------
    // RAM ports
    // ---------------------------------------------------------------
    logic                          link_we, link_re;
    cll_pkg::t_ptr                 link_waddr, link_raddr, link_wdata, link_q;
    logic                          data_we, data_re;
    cll_pkg::t_ptr                 data_waddr, data_raddr;
    logic [cll_pkg::ELEM_BITS-1:0] data_wdata, data_q;

    cll_ram #(
        .WIDTH (cll_pkg::PTR_W),
        .DEPTH (cll_pkg::SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_q)
    );

    cll_ram #(
        .WIDTH (cll_pkg::ELEM_BITS),
        .DEPTH (cll_pkg::SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (data_re),
        .i_raddr (data_raddr),
        .o_rdata (data_q)
    );

    logic out_free;
    logic link_end;     // link just read ends the chain
    assign out_free = !r_out_valid || i_out_ready;
    assign link_end = (link_q == cll_pkg::FREE_SLOT);

    // Range checks on the incoming position
    logic pos_zero, ins_bad, del_bad;
    assign pos_zero = (i_in_word.position == '0);
    assign ins_bad  = pos_zero ||
        ({1'b0, i_in_word.position} >
         ({1'b0, r_count} + (cll_pkg::LEN_W + 1)'(1)));
    assign del_bad  = pos_zero ||
        ({1'b0, i_in_word.position} > {1'b0, r_count});

    // ---------------------------------------------------------------
    // Next state and register updates
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_status    = r_status;
        n_cnt       = r_cnt;
        n_elem      = r_elem;
        n_ptr       = r_ptr;
        n_slot      = r_slot;
        n_count     = r_count;
        n_init_idx  = r_init_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        case (r_state)
            cll_pkg::S_INIT: begin
                n_init_idx = r_init_idx + cll_pkg::t_ptr'(1);
                if (r_init_idx == cll_pkg::HEAD_SLOT) begin
                    n_state = cll_pkg::S_IDLE;
                end
            end
            cll_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_in_word.mode;
                    n_elem   = i_in_word.element;
                    n_cnt    = i_in_word.position - cll_pkg::POS_W'(1);
                    n_ptr    = cll_pkg::HEAD_SLOT;
                    n_status = cll_pkg::ST_OK;
                    case (i_in_word.mode)
                        cll_pkg::MODE_INSERT: begin
                            if (ins_bad) begin
                                n_status = cll_pkg::ST_RANGE;
                                n_state  = cll_pkg::S_RESULT;
                            end else begin
                                n_state  = cll_pkg::S_INS_RD0;
                            end
                        end
                        cll_pkg::MODE_DELETE: begin
                            if (del_bad) begin
                                n_status = cll_pkg::ST_RANGE;
                                n_state  = cll_pkg::S_RESULT;
                            end else begin
                                n_state  = cll_pkg::S_W_HEAD;
                            end
                        end
                        cll_pkg::MODE_TRAVERSE: begin
                            if (r_count == '0) begin
                                n_state = cll_pkg::S_RESULT;
                            end else begin
                                n_state = cll_pkg::S_T_HEAD;
                            end
                        end
                        default: begin
                            n_state = cll_pkg::S_RESULT;
                        end
                    endcase
                end
            end
            cll_pkg::S_INS_RD0: begin
                n_state = cll_pkg::S_INS_FRESH;
            end
            cll_pkg::S_INS_FRESH: begin
                if (link_end) begin
                    n_status = cll_pkg::ST_FULL;
                    n_state  = cll_pkg::S_RESULT;
                end else begin
                    n_slot  = link_q;
                    n_state = cll_pkg::S_INS_UNFREE;
                end
            end
            cll_pkg::S_INS_UNFREE: begin
                n_state = cll_pkg::S_W_HEAD;
            end
            cll_pkg::S_W_HEAD: begin
                n_state = cll_pkg::S_WALK;
            end
            cll_pkg::S_WALK: begin
                if (r_cnt == '0) begin
                    // r_ptr is the predecessor, link_q its successor
                    if (r_mode == cll_pkg::MODE_INSERT) begin
                        n_state = cll_pkg::S_INS_LINK;
                    end else begin
                        n_slot  = link_q;
                        n_state = cll_pkg::S_DEL_V;
                    end
                end else begin
                    n_cnt = r_cnt - cll_pkg::POS_W'(1);
                    n_ptr = link_q;
                end
            end
            cll_pkg::S_INS_LINK: begin
                n_count = r_count + cll_pkg::LEN_W'(1);
                n_state = cll_pkg::S_RESULT;
            end
            cll_pkg::S_DEL_V: begin
                n_state = cll_pkg::S_DEL_F;
            end
            cll_pkg::S_DEL_F: begin
                n_state = cll_pkg::S_DEL_H;
            end
            cll_pkg::S_DEL_H: begin
                n_count = r_count - cll_pkg::LEN_W'(1);
                n_state = cll_pkg::S_RESULT;
            end
            cll_pkg::S_T_HEAD: begin
                n_state = cll_pkg::S_T_ADDR;
            end
            cll_pkg::S_T_ADDR: begin
                n_state = cll_pkg::S_T_DATA;
            end
            cll_pkg::S_T_DATA: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = cll_pkg::ST_OK;
                    n_out.element_out   = $signed(cll_pkg::ELEM_W'(data_q));
                    n_out.list_length   = r_count;
                    n_out.last          = link_end;
                    if (link_end) begin
                        n_state = cll_pkg::S_IDLE;
                    end
                end
            end
            cll_pkg::S_RESULT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.element_out   = '0;
                    n_out.list_length   = r_count;
                    n_out.last          = 1'b1;
                    n_state             = cll_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cll_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // RAM control and handshake outputs
    // ---------------------------------------------------------------
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_ptr;
        link_wdata = link_q;
        link_re    = 1'b0;
        link_raddr = link_q;
        data_we    = 1'b0;
        data_waddr = link_q;
        data_wdata = cll_pkg::ELEM_BITS'(r_elem);
        data_re    = 1'b0;
        data_raddr = link_q;
        o_in_ready = 1'b0;

        case (r_state)
            cll_pkg::S_INIT: begin
                // free chain 0 -> 1 -> ... -> SLOTS-2 -> end, list empty
                link_we    = 1'b1;
                link_waddr = r_init_idx;
                link_wdata = (r_init_idx < cll_pkg::LAST_FREE) ?
                             r_init_idx + cll_pkg::t_ptr'(1) : cll_pkg::FREE_SLOT;
            end
            cll_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            cll_pkg::S_INS_RD0: begin
                link_re    = 1'b1;
                link_raddr = cll_pkg::FREE_SLOT;
            end
            cll_pkg::S_INS_FRESH: begin
                // fetch the fresh slot's link and store the element there
                if (!link_end) begin
                    link_re = 1'b1;
                    data_we = 1'b1;
                end
            end
            cll_pkg::S_INS_UNFREE: begin
                link_we    = 1'b1;
                link_waddr = cll_pkg::FREE_SLOT;
            end
            cll_pkg::S_W_HEAD: begin
                link_re    = 1'b1;
                link_raddr = cll_pkg::HEAD_SLOT;
            end
            cll_pkg::S_WALK: begin
                if (r_cnt == '0 && r_mode == cll_pkg::MODE_INSERT) begin
                    link_we    = 1'b1;
                    link_waddr = r_slot;    // fresh -> successor
                end else begin
                    link_re    = 1'b1;      // next hop, or the victim's link
                end
            end
            cll_pkg::S_INS_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_ptr;         // predecessor -> fresh
                link_wdata = r_slot;
            end
            cll_pkg::S_DEL_V: begin
                link_we    = 1'b1;          // predecessor -> victim's successor
                link_waddr = r_ptr;
                link_re    = 1'b1;
                link_raddr = cll_pkg::FREE_SLOT;
            end
            cll_pkg::S_DEL_F: begin
                link_we    = 1'b1;          // victim -> old free head
                link_waddr = r_slot;
            end
            cll_pkg::S_DEL_H: begin
                link_we    = 1'b1;          // free head -> victim
                link_waddr = cll_pkg::FREE_SLOT;
                link_wdata = r_slot;
            end
            cll_pkg::S_T_HEAD: begin
                link_re    = 1'b1;
                link_raddr = cll_pkg::HEAD_SLOT;
            end
            cll_pkg::S_T_ADDR: begin
                link_re = 1'b1;
                data_re = 1'b1;
            end
            cll_pkg::S_T_DATA: begin
                // read data holds while the output register is full
                if (out_free && !link_end) begin
                    link_re = 1'b1;
                    data_re = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequential
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cll_pkg::S_INIT;
            r_count     <= '0;
            r_init_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_init_idx  <= n_init_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_status <= n_status;
        r_cnt    <= n_cnt;
        r_elem   <= n_elem;
        r_ptr    <= n_ptr;
        r_slot   <= n_slot;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/cll_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cll_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire cll_pkg::t_out_word o_out_word
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // only a traverse run gives words that are not last, and those are ok
    a_run_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |-> o_out_word.status == cll_pkg::ST_OK &&
                                            o_out_word.list_length != '0)
        else $error("bad status inside traverse run");

    // block is busy while a traverse run is still open
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |-> !o_in_ready)
        else $error("input taken during traverse run");

    // the list never exceeds the usable slots
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.list_length <= cll_pkg::LEN_W'(cll_pkg::SLOTS - 2))
        else $error("list length above capacity");

endmodule

bind cursor_linked_list_engine cll_checker u_cll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire

>>> bench/cursor_linked_list_engine_tb.sv
`timescale 1ns / 1ps

// Bench for the cursor linked list engine.
//
// A shadow copy of the list (a queue of elements in list order) tracks every
// accepted command word and predicts the result words: status, element,
// length after the operation and the end-of-run flag. The sender and the
// receiver run in their own processes, both with random idle bursts, and the
// receiver also does one long hold so the block backs up into its input.
//
// Run outline:
//   directed   - empty-list corners, range errors at both ends, mode 3
//   grow       - mostly inserts until the list is full and refuses more
//   full scan  - one traversal over all 62 elements
//   mixed      - everything, no idling, receiver blocked for a while
//   shrink     - mostly deletes, backing off the full mark
//   final      - short mixed run with no idling at all

module cursor_linked_list_engine_tb;

    import cll_pkg::*;

    localparam int    CAPACITY       = SLOTS - 2;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    WATCHDOG_LIMIT = 3000;
    localparam int    TAIL_CYCLES    = 80;
    localparam t_mode MODE_UNDEF     = t_mode'(2'd3);

    // ------------------------------------------------------------------
    // Scoreboard: shadow list plus the queue of result words still due
    // ------------------------------------------------------------------
    class list_mirror;
        logic signed [ELEM_W-1:0] elems[$];
        t_out_word                due_words[$];
        int errors;
        int n_words;
        int n_results;
        int n_full;
        int n_range;
        int n_runs;

        function int depth();
            return elems.size();
        endfunction

        function void push_due(t_status st, logic signed [ELEM_W-1:0] e, logic fin);
            t_out_word r;
            r.status      = st;
            r.element_out = e;
            r.list_length = LEN_W'(elems.size());
            r.last        = fin;
            due_words.push_back(r);
            if (st == ST_FULL) n_full++;
            if (st == ST_RANGE) n_range++;
        endfunction

        // Accepted command word: update the shadow list, queue its results.
        function void apply_command(t_in_word w);
            int len;
            int p;
            len = elems.size();
            p   = w.position;
            n_words++;
            case (w.mode)
                MODE_INSERT: begin
                    // position is checked before the free chain
                    if (p < 1 || p > len + 1) begin
                        push_due(ST_RANGE, '0, 1'b1);
                    end else if (len == CAPACITY) begin
                        push_due(ST_FULL, '0, 1'b1);
                    end else begin
                        elems.insert(p - 1, w.element);
                        push_due(ST_OK, '0, 1'b1);
                    end
                end
                MODE_DELETE: begin
                    if (p < 1 || p > len) begin
                        push_due(ST_RANGE, '0, 1'b1);
                    end else begin
                        elems.delete(p - 1);
                        push_due(ST_OK, '0, 1'b1);
                    end
                end
                MODE_TRAVERSE: begin
                    n_runs++;
                    if (len == 0) begin
                        push_due(ST_OK, '0, 1'b1);
                    end else begin
                        foreach (elems[i]) push_due(ST_OK, elems[i], i == len - 1);
                    end
                end
                default: begin
                    // undefined mode: no change, one plain word
                    push_due(ST_OK, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_field(string f, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", f, want, got);
                errors++;
            end
        endfunction

        // Accepted result word: compare against the oldest pending one.
        function void compare_result(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                $error("unexpected result word: status %0d element %0d length %0d last %0d",
                       got.status, got.element_out, got.list_length, got.last);
                errors++;
                return;
            end
            want = due_words.pop_front();
            n_results++;
            check_field("status", want.status, got.status);
            check_field("element_out", want.element_out, got.element_out);
            check_field("list_length", want.list_length, got.list_length);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    // knobs set by the stimulus for the sender and the receiver, plus the watchdog count
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic hold_asked = 1'b0;
    int   quiet_cycles = 0;

    list_mirror mirror = new();

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cursor_linked_list_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic t_in_word cmd(t_mode m, logic [POS_W-1:0] p,
                                     logic [ELEM_W-1:0] e);
        t_in_word w;
        w.mode     = m;
        w.position = p;
        w.element  = e;
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back words follow without valid dropping.
    task automatic send_word(input t_in_word w);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        mirror.apply_command(w);
        @(negedge clk);
    endtask

    // Drop valid, then hold off until every pending result word is back.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (mirror.due_words.size() != 0) @(negedge clk);
    endtask

    // Weighted random word. Inserts and deletes aim at valid positions from
    // the shadow length; the rest is noise over the full field ranges.
    task automatic send_random(input int p_ins, input int p_del, input int p_trv);
        t_in_word w;
        int       roll;
        int       len;
        roll      = $urandom_range(0, 99);
        len       = mirror.depth();
        w.element = $urandom();
        if (roll < p_ins) begin
            w.mode     = MODE_INSERT;
            w.position = POS_W'($urandom_range(1, len + 1));
        end else if (roll < p_ins + p_del) begin
            w.mode     = MODE_DELETE;
            w.position = (len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, len));
        end else if (roll < p_ins + p_del + p_trv) begin
            w.mode     = MODE_TRAVERSE;
            w.position = POS_W'($urandom_range(0, 63));
        end else begin
            w.mode     = t_mode'($urandom_range(0, 3));
            w.position = POS_W'($urandom_range(0, 63));
        end
        send_word(w);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (hold_asked) begin
                // long block so the engine fills and stops taking words
                hold_asked = 1'b0;
                out_ready <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end else if (rx_idle_on && $urandom_range(0, 99) < 8) begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) mirror.compare_result(out_word);
    end

    // Watchdog: too long without a word moving on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed corners; the engine builds its free chain first, the
        // first word just waits on ready.
        send_word(cmd(MODE_TRAVERSE, 6'd0, 32'h0));          // empty list
        send_word(cmd(MODE_DELETE, 6'd1, 32'h0));            // delete on empty
        send_word(cmd(MODE_DELETE, 6'd63, 32'hFFFF_FFFF));
        send_word(cmd(MODE_INSERT, 6'd0, 32'h1234_5678));    // position zero
        send_word(cmd(MODE_INSERT, 6'd2, 32'h1));            // past end+1
        send_word(cmd(MODE_INSERT, 6'd1, 32'h7FFF_FFFF));
        send_word(cmd(MODE_INSERT, 6'd1, 32'h8000_0000));    // new head
        send_word(cmd(MODE_INSERT, 6'd3, 32'h0));            // append
        send_word(cmd(MODE_INSERT, 6'd2, 32'hFFFF_FFFF));    // middle
        send_word(cmd(MODE_INSERT, 6'd5, 32'h5555_5555));
        send_word(cmd(MODE_INSERT, 6'd1, 32'hAAAA_AAAA));
        send_word(cmd(MODE_INSERT, 6'd63, 32'h0));           // way out of range
        send_word(cmd(MODE_TRAVERSE, 6'd63, 32'hFFFF_FFFF));
        send_word(cmd(MODE_UNDEF, 6'd63, 32'hFFFF_FFFF));
        send_word(cmd(MODE_DELETE, 6'd0, 32'h0));
        send_word(cmd(MODE_DELETE, 6'd7, 32'h0));            // one past length
        send_word(cmd(MODE_DELETE, 6'd6, 32'h0));            // tail
        send_word(cmd(MODE_DELETE, 6'd1, 32'h0));            // head
        send_word(cmd(MODE_DELETE, 6'd2, 32'h0));
        send_word(cmd(MODE_TRAVERSE, 6'd0, 32'h0));
        send_word(cmd(MODE_UNDEF, 6'd0, 32'h0));
        drain();

        // Grow until full and a few inserts have bounced off.
        while (mirror.n_full < 3) send_random(96, 2, 1);
        send_word(cmd(MODE_TRAVERSE, 6'd0, 32'h0));          // full-length run
        send_word(cmd(MODE_DELETE, 6'd63, 32'h0));           // beyond a full list
        drain();

        // Mixed traffic with no idling while the receiver blocks for a while.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_asked = 1'b1;
        repeat (10) send_random(30, 30, 25);
        drain();

        // Shrink back down.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        while (mirror.depth() > 54) send_random(8, 80, 7);
        drain();

        // Last stretch: no idling on either side.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (6) send_random(30, 30, 25);
        send_word(cmd(MODE_TRAVERSE, 6'd0, 32'h0));
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d command words, %0d result words, %0d traversals",
                 mirror.n_words, mirror.n_results, mirror.n_runs);
        $display("range errors %0d, full-list refusals %0d, final length %0d",
                 mirror.n_range, mirror.n_full, mirror.depth());
        if (mirror.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> cursor_linked_list_engine.f
hw/rtl/cll_pkg.sv
hw/rtl/cll_ram.sv
hw/rtl/cursor_linked_list_engine.sv
hw/rtl/cll_checker.sv
bench/cursor_linked_list_engine_tb.sv
